[hdl/lli_pkg.sv]
// Shared types and constants for the line-line intersection block.
`default_nettype none
package lli_pkg;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned DIFF_W  = COORD_W + 1;      // point difference
   localparam int unsigned PROD_W  = 2 * COORD_W;      // coordinate product
   localparam int unsigned CROSS_W = PROD_W + 1;       // cross term c12, c34
   localparam int unsigned DPROD_W = 2 * DIFF_W;       // difference product
   localparam int unsigned DEN_W   = DPROD_W + 1;      // denominator
   localparam int unsigned PART_W  = 2 * DIFF_W;       // partial product
   localparam int unsigned NUM_W   = CROSS_W + DIFF_W + 1; // numerator
   localparam int unsigned QUO_W   = COORD_W;          // quotient bits
   localparam int unsigned FRONT_STAGES = 5;
   localparam int unsigned QUEUE_DEPTH  = 2;

   typedef struct packed {
      logic [COORD_W-1:0] line_a_start_x;
      logic [COORD_W-1:0] line_a_start_y;
      logic [COORD_W-1:0] line_a_end_x;
      logic [COORD_W-1:0] line_a_end_y;
      logic [COORD_W-1:0] line_b_start_x;
      logic [COORD_W-1:0] line_b_start_y;
      logic [COORD_W-1:0] line_b_end_x;
      logic [COORD_W-1:0] line_b_end_y;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] cross_x;
      logic [COORD_W-1:0] cross_y;
      logic               parallel;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic [NUM_W-1:0] nx;
      logic [NUM_W-1:0] ny;
      logic [DEN_W-1:0] den;
   } job_type;

   typedef struct packed {
      logic               valid;
      logic [QUO_W-1:0]   quo;
      logic               ovf;
      logic               zero;
   } div_out_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

[hdl/lli_front.sv]
// Front pipeline: differences, cross terms, denominator and numerators.
`default_nettype none
module lli_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire lli_pkg::req_type in_data,
   output logic                  out_valid,
   output lli_pkg::job_type      out_job
);

   logic [lli_pkg::FRONT_STAGES-1:0] valid_ff;

   // stage 1
   logic signed [lli_pkg::DIFF_W-1:0] dx12_ff, dy12_ff, dx34_ff, dy34_ff;
   logic signed [lli_pkg::PROD_W-1:0] p1_ff, p2_ff, p3_ff, p4_ff;
   // stage 2
   logic signed [lli_pkg::DIFF_W-1:0]  dx12_2_ff, dy12_2_ff, dx34_2_ff, dy34_2_ff;
   logic signed [lli_pkg::CROSS_W-1:0] c12_ff, c34_ff;
   logic signed [lli_pkg::DPROD_W-1:0] dd1_ff, dd2_ff;
   // stage 3
   logic signed [lli_pkg::DEN_W-1:0]  den3_ff;
   logic signed [lli_pkg::PART_W-1:0] h1_ff, l1_ff, h2_ff, l2_ff, h3_ff, l3_ff, h4_ff, l4_ff;
   // stage 4
   logic signed [lli_pkg::DEN_W-1:0] den4_ff;
   logic signed [lli_pkg::NUM_W-1:0] t1_ff, t2_ff, t3_ff, t4_ff;
   // stage 5
   lli_pkg::job_type job_ff;

   logic signed [lli_pkg::COORD_W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
   logic signed [lli_pkg::DIFF_W-1:0]  c12h, c12l, c34h, c34l;

   assign x1 = $signed(in_data.line_a_start_x);
   assign y1 = $signed(in_data.line_a_start_y);
   assign x2 = $signed(in_data.line_a_end_x);
   assign y2 = $signed(in_data.line_a_end_y);
   assign x3 = $signed(in_data.line_b_start_x);
   assign y3 = $signed(in_data.line_b_start_y);
   assign x4 = $signed(in_data.line_b_end_x);
   assign y4 = $signed(in_data.line_b_end_y);

   // split cross terms into a signed high part and an unsigned low word
   assign c12h = $signed(c12_ff[lli_pkg::CROSS_W-1:lli_pkg::COORD_W]);
   assign c12l = $signed({1'b0, c12_ff[lli_pkg::COORD_W-1:0]});
   assign c34h = $signed(c34_ff[lli_pkg::CROSS_W-1:lli_pkg::COORD_W]);
   assign c34l = $signed({1'b0, c34_ff[lli_pkg::COORD_W-1:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[lli_pkg::FRONT_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      dx12_ff <= lli_pkg::DIFF_W'(x1) - lli_pkg::DIFF_W'(x2);
      dy12_ff <= lli_pkg::DIFF_W'(y1) - lli_pkg::DIFF_W'(y2);
      dx34_ff <= lli_pkg::DIFF_W'(x3) - lli_pkg::DIFF_W'(x4);
      dy34_ff <= lli_pkg::DIFF_W'(y3) - lli_pkg::DIFF_W'(y4);
      p1_ff   <= lli_pkg::PROD_W'(x1) * lli_pkg::PROD_W'(y2);
      p2_ff   <= lli_pkg::PROD_W'(y1) * lli_pkg::PROD_W'(x2);
      p3_ff   <= lli_pkg::PROD_W'(x3) * lli_pkg::PROD_W'(y4);
      p4_ff   <= lli_pkg::PROD_W'(y3) * lli_pkg::PROD_W'(x4);

      dx12_2_ff <= dx12_ff;
      dy12_2_ff <= dy12_ff;
      dx34_2_ff <= dx34_ff;
      dy34_2_ff <= dy34_ff;
      c12_ff    <= lli_pkg::CROSS_W'(p1_ff) - lli_pkg::CROSS_W'(p2_ff);
      c34_ff    <= lli_pkg::CROSS_W'(p3_ff) - lli_pkg::CROSS_W'(p4_ff);
      dd1_ff    <= lli_pkg::DPROD_W'(dx12_ff) * lli_pkg::DPROD_W'(dy34_ff);
      dd2_ff    <= lli_pkg::DPROD_W'(dy12_ff) * lli_pkg::DPROD_W'(dx34_ff);

      den3_ff <= lli_pkg::DEN_W'(dd1_ff) - lli_pkg::DEN_W'(dd2_ff);
      h1_ff   <= lli_pkg::PART_W'(c12h) * lli_pkg::PART_W'(dx34_2_ff);
      l1_ff   <= lli_pkg::PART_W'(c12l) * lli_pkg::PART_W'(dx34_2_ff);
      h2_ff   <= lli_pkg::PART_W'(c34h) * lli_pkg::PART_W'(dx12_2_ff);
      l2_ff   <= lli_pkg::PART_W'(c34l) * lli_pkg::PART_W'(dx12_2_ff);
      h3_ff   <= lli_pkg::PART_W'(c12h) * lli_pkg::PART_W'(dy34_2_ff);
      l3_ff   <= lli_pkg::PART_W'(c12l) * lli_pkg::PART_W'(dy34_2_ff);
      h4_ff   <= lli_pkg::PART_W'(c34h) * lli_pkg::PART_W'(dy12_2_ff);
      l4_ff   <= lli_pkg::PART_W'(c34l) * lli_pkg::PART_W'(dy12_2_ff);

      den4_ff <= den3_ff;
      t1_ff <= (lli_pkg::NUM_W'(h1_ff) <<< lli_pkg::COORD_W) + lli_pkg::NUM_W'(l1_ff);
      t2_ff <= (lli_pkg::NUM_W'(h2_ff) <<< lli_pkg::COORD_W) + lli_pkg::NUM_W'(l2_ff);
      t3_ff <= (lli_pkg::NUM_W'(h3_ff) <<< lli_pkg::COORD_W) + lli_pkg::NUM_W'(l3_ff);
      t4_ff <= (lli_pkg::NUM_W'(h4_ff) <<< lli_pkg::COORD_W) + lli_pkg::NUM_W'(l4_ff);

      job_ff.nx  <= t1_ff - t2_ff;
      job_ff.ny  <= t3_ff - t4_ff;
      job_ff.den <= den4_ff;
   end

   assign out_valid = valid_ff[lli_pkg::FRONT_STAGES-1];
   assign out_job   = job_ff;

endmodule
`default_nettype wire

[hdl/lli_queue.sv]
// Short job queue between the front pipeline and the dividers.
`default_nettype none
module lli_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lli_pkg::job_type     push_job,
   input  wire logic                 pop,
   output lli_pkg::job_type          head_job,
   output lli_pkg::queue_status_type status
);

   localparam int unsigned PTR_W = $clog2(lli_pkg::QUEUE_DEPTH);

   lli_pkg::job_type              slot_ff [lli_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]              wptr_ff, rptr_ff;
   logic [PTR_W:0]                count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         count_ff <= count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

   assign head_job     = slot_ff[rptr_ff];
   assign status.full  = (count_ff == (PTR_W+1)'(lli_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule
`default_nettype wire

[hdl/lli_div.sv]
// Pipelined signed divider, one quotient bit per stage, saturated to 32 bits.
`default_nettype none
module lli_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire logic [lli_pkg::NUM_W-1:0] num,
   input  wire logic [lli_pkg::DEN_W-1:0] den,
   output lli_pkg::div_out_type           result
);

   localparam int unsigned N = lli_pkg::NUM_W;
   localparam int unsigned D = lli_pkg::DEN_W;
   localparam int unsigned Q = lli_pkg::QUO_W;

   // magnitude stage
   logic          v0_ff, neg0_ff, zero0_ff;
   logic [N-1:0]  a0_ff;
   logic [D-1:0]  b0_ff;

   // bit stages: index 0 feeds the first quotient bit
   logic          v_ff    [Q+1];
   logic          neg_ff  [Q+1];
   logic          zero_ff [Q+1];
   logic          big_ff  [Q+1];
   logic [N-1:0]  rem_ff  [Q+1];
   logic [D-1:0]  b_ff    [Q+1];
   logic [Q-1:0]  quo_ff  [Q+1];

   lli_pkg::div_out_type out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
      end
      a0_ff    <= num[N-1] ? (~num + N'(1)) : num;
      b0_ff    <= den[D-1] ? (~den + D'(1)) : den;
      neg0_ff  <= num[N-1] ^ den[D-1];
      zero0_ff <= (den == '0);
   end

   // quotient of 2^32 or more saturates regardless of sign
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= v0_ff;
      end
      neg_ff[0]  <= neg0_ff;
      zero_ff[0] <= zero0_ff;
      big_ff[0]  <= (a0_ff >= {b0_ff, {Q{1'b0}}});
      rem_ff[0]  <= a0_ff;
      b_ff[0]    <= b0_ff;
      quo_ff[0]  <= '0;
   end

   for (genvar k = 0; k < Q; k++) begin : g_bit
      logic [N-1:0] shifted;
      logic         take;
      assign shifted = N'(b_ff[k]) << (Q - 1 - k);
      assign take    = (rem_ff[k] >= shifted);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else begin
            v_ff[k+1] <= v_ff[k];
         end
         neg_ff[k+1]  <= neg_ff[k];
         zero_ff[k+1] <= zero_ff[k];
         big_ff[k+1]  <= big_ff[k];
         b_ff[k+1]    <= b_ff[k];
         rem_ff[k+1]  <= take ? (rem_ff[k] - shifted) : rem_ff[k];
         quo_ff[k+1]  <= quo_ff[k] | (Q'(take) << (Q - 1 - k));
      end
   end

   // apply sign and saturate
   logic [Q-1:0] q;
   logic         sat;
   assign q   = quo_ff[Q];
   assign sat = big_ff[Q] ||
                (neg_ff[Q] ? (q > {1'b1, {(Q-1){1'b0}}}) : q[Q-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= v_ff[Q];
      end
      out_ff.zero <= zero_ff[Q];
      out_ff.ovf  <= sat;
      if (sat) begin
         out_ff.quo <= neg_ff[Q] ? {1'b1, {(Q-1){1'b0}}} : {1'b0, {(Q-1){1'b1}}};
      end else begin
         out_ff.quo <= neg_ff[Q] ? (~q + Q'(1)) : q;
      end
   end

   assign result = out_ff;

endmodule
`default_nettype wire

[hdl/line_line_intersection.sv]
// Top level of the line-line intersection block.
// Takes two lines, each as two points in signed Q16.16, and returns the point
// where the infinite lines cross, each coordinate truncated toward zero and
// saturated to 32 bits, with overflow set on saturation. When the common
// denominator is zero (parallel, coincident or degenerate lines) both
// coordinates are zero and parallel is set. A new line pair may be started
// every clock cycle; busy stays low in normal use since the dividers drain the
// queue every cycle. Each result appears on rsp_data for exactly one cycle,
// flagged by rsp_valid, after its start transfer has passed the front pipeline
// of products and sums, a slot in the queue, the two divider pipelines
// (a magnitude stage, a range check stage, one quotient bit per stage and a
// saturation register) and one output register. The receiver cannot stall:
// it must take every result as shown.
`default_nettype none
module line_line_intersection (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire lli_pkg::req_type req_data,
   output logic                  rsp_valid,
   output lli_pkg::rsp_type      rsp_data
);

   logic                      front_valid;
   lli_pkg::job_type          front_job;
   lli_pkg::job_type          head_job;
   lli_pkg::queue_status_type q_status;
   logic                      pop;
   lli_pkg::div_out_type      div_x, div_y;

   logic                      rsp_valid_ff;
   lli_pkg::rsp_type          rsp_data_ff;

   // Reduce each pair to numerators and denominator.
   lli_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_job   (front_job)
   );

   // Drain the queue whenever it holds a job.
   assign pop  = !q_status.empty;
   assign busy = q_status.full;

   lli_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .push_job (front_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   lli_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pop),
      .num      (head_job.nx),
      .den      (head_job.den),
      .result   (div_x)
   );

   lli_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pop),
      .num      (head_job.ny),
      .den      (head_job.den),
      .result   (div_y)
   );

   // Drop the quotients on a zero denominator and report parallel instead.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_x.valid && div_y.valid;
      end
      rsp_data_ff.cross_x  <= div_x.zero ? '0 : div_x.quo;
      rsp_data_ff.cross_y  <= div_x.zero ? '0 : div_y.quo;
      rsp_data_ff.parallel <= div_x.zero;
      rsp_data_ff.overflow <= !div_x.zero && (div_x.ovf || div_y.ovf);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

[sim/line_line_intersection_tb.sv]
// Self-checking testbench for the line-line intersection block.
`timescale 1ns / 100ps
`default_nettype none
module line_line_intersection_tb;

   localparam logic [31:0] ONE  = 32'h0001_0000;
   localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
   localparam logic [31:0] MINV = 32'h8000_0000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   lli_pkg::req_type req_data = '0;
   logic             rsp_valid;
   lli_pkg::rsp_type rsp_data;

   // pending line pairs for the driver, predicted crossings for the monitor
   lli_pkg::req_type pair_queue[$];
   lli_pkg::rsp_type crossing_queue[$];
   int               mismatch_count = 0;
   bit               stimulus_done = 1'b0;
   int               gap_left = 0;
   logic             busy_at_edge = 1'b0;

   line_line_intersection uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // Saturate an exact signed quotient to 32 bits; note overflow on clamp.
   function automatic logic [31:0] clamp_quotient(input logic signed [191:0] q,
                                                   inout logic ovf);
      if (q > 192'sd2147483647) begin
         ovf = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (q < -192'sd2147483648) begin
         ovf = 1'b1;
         return 32'h8000_0000;
      end
      return q[31:0];
   endfunction

   // Work out the crossing point exactly at wide signed width.
   function automatic lli_pkg::rsp_type predict_crossing(input lli_pkg::req_type p);
      logic signed [191:0] x1, y1, x2, y2, x3, y3, x4, y4;
      logic signed [191:0] dx12, dy12, dx34, dy34, c12, c34, den, nx, ny;
      lli_pkg::rsp_type r;
      logic    ovf;
      x1 = $signed(p.line_a_start_x); y1 = $signed(p.line_a_start_y);
      x2 = $signed(p.line_a_end_x);   y2 = $signed(p.line_a_end_y);
      x3 = $signed(p.line_b_start_x); y3 = $signed(p.line_b_start_y);
      x4 = $signed(p.line_b_end_x);   y4 = $signed(p.line_b_end_y);
      dx12 = x1 - x2; dy12 = y1 - y2; dx34 = x3 - x4; dy34 = y3 - y4;
      c12 = x1 * y2 - y1 * x2;
      c34 = x3 * y4 - y3 * x4;
      den = dx12 * dy34 - dy12 * dx34;
      r = '0;
      if (den == 0) begin
         r.parallel = 1'b1;
         return r;
      end
      nx = c12 * dx34 - dx12 * c34;
      ny = c12 * dy34 - dy12 * c34;
      ovf = 1'b0;
      // SystemVerilog signed division truncates toward zero
      r.cross_x = clamp_quotient(nx / den, ovf);
      r.cross_y = clamp_quotient(ny / den, ovf);
      r.overflow = ovf;
      return r;
   endfunction

   function automatic logic [31:0] rand_coord(input int kind);
      case (kind)
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
         default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      endcase
   endfunction

   // Build a random pair; some share a slope or repeat a point on purpose.
   function automatic lli_pkg::req_type random_pair();
      lli_pkg::req_type p;
      int      kind;
      logic [31:0] sx, sy;
      kind = $urandom_range(0, 3);
      p.line_a_start_x = rand_coord(kind); p.line_a_start_y = rand_coord(kind);
      p.line_a_end_x   = rand_coord(kind); p.line_a_end_y   = rand_coord(kind);
      p.line_b_start_x = rand_coord(kind); p.line_b_start_y = rand_coord(kind);
      p.line_b_end_x   = rand_coord(kind); p.line_b_end_y   = rand_coord(kind);
      case ($urandom_range(0, 9))
         0: begin
            // parallel: second line offset by the same direction vector
            sx = p.line_a_end_x - p.line_a_start_x;
            sy = p.line_a_end_y - p.line_a_start_y;
            p.line_b_end_x = p.line_b_start_x + sx;
            p.line_b_end_y = p.line_b_start_y + sy;
         end
         1: begin
            p.line_a_end_x = p.line_a_start_x;
            p.line_a_end_y = p.line_a_start_y;
         end
         2: begin
            // nearly parallel lines push the quotient out of range
            p.line_b_end_x = p.line_b_start_x + p.line_a_end_x - p.line_a_start_x;
            p.line_b_end_y = p.line_b_start_y + p.line_a_end_y - p.line_a_start_y
                             + 32'($urandom_range(1, 3));
         end
         default: ;
      endcase
      return p;
   endfunction

   function automatic lli_pkg::req_type make_pair(input logic [31:0] a, b, c, d,
                                                  input logic [31:0] e, f, g, h);
      return '{a, b, c, d, e, f, g, h};
   endfunction

   // Mostly random gaps, with runs of back-to-back transfers.
   function automatic int draw_gap();
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
   endfunction

   // Fill the queue: directed pairs first, then random ones.
   initial begin
      // plain crossing at the origin
      pair_queue.push_back(make_pair(-ONE, 0, ONE, 0, 0, -ONE, 0, ONE));
      // crossing off the origin with a negative result
      pair_queue.push_back(make_pair(-3*ONE, ONE, ONE, ONE, -2*ONE, 0, -2*ONE, 5*ONE));
      // parallel lines
      pair_queue.push_back(make_pair(0, 0, ONE, ONE, 0, ONE, ONE, 2*ONE));
      // coincident lines
      pair_queue.push_back(make_pair(0, 0, ONE, ONE, 2*ONE, 2*ONE, 3*ONE, 3*ONE));
      // degenerate line with two equal points
      pair_queue.push_back(make_pair(ONE, ONE, ONE, ONE, 0, 0, ONE, 0));
      pair_queue.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      // extreme coordinates
      pair_queue.push_back(make_pair(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
      pair_queue.push_back(make_pair(MINV, MINV, MAXV, MAXV, MINV, MAXV, MAXV, MINV));
      pair_queue.push_back(make_pair(MINV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MAXV));
      pair_queue.push_back(make_pair(MINV, 0, MAXV, 0, 0, MINV, 0, MAXV));
      pair_queue.push_back(make_pair(MAXV, MINV, MINV, MAXV, 0, 0, 1, 0));
      // small slopes and unit offsets; one of these saturates
      pair_queue.push_back(make_pair(0, 0, ONE, 0, 0, 1, ONE, 2));
      pair_queue.push_back(make_pair(0, 0, ONE, 0, 0, 1, ONE, 0));
      pair_queue.push_back(make_pair(0, 0, MAXV, 0, 0, MINV, MAXV, MINV + 1));
      pair_queue.push_back(make_pair(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     0, 1, 32'hFFFF_FFFF, 0));
      pair_queue.push_back(make_pair(32'hFFFF_FFFF, 0, 1, 0, 0, 32'hFFFF_FFFF, 0, 1));
      repeat (1035) pair_queue.push_back(random_pair());
      stimulus_done = 1'b1;
   end

   // Driver: present one pair per transfer with a random gap in between.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy_at_edge) begin
         // previous transfer taken at the last rising edge
         if (gap_left == 0 && pair_queue.size() > 0) begin
            req_data <= pair_queue.pop_front();
            gap_left <= draw_gap();
         end else begin
            start <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pair_queue.size() > 0) begin
            req_data <= pair_queue.pop_front();
            start    <= 1'b1;
            gap_left <= draw_gap();
         end
      end
   end

   // Sample the handshake at the rising edge; predict on each transfer.
   always @(posedge clock) begin
      busy_at_edge <= busy;
      if (!reset && start && !busy) begin
         crossing_queue.push_back(predict_crossing(req_data));
      end
   end

   // Monitor: every strobed result must match the oldest prediction.
   always @(posedge clock) begin
      lli_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (crossing_queue.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
               $display("unexpected result x=%h y=%h par=%b ovf=%b", rsp_data.cross_x,
                        rsp_data.cross_y, rsp_data.parallel, rsp_data.overflow);
         end else begin
            want = crossing_queue.pop_front();
            if (want !== rsp_data) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("mismatch: want x=%h y=%h par=%b ovf=%b, got x=%h y=%h par=%b ovf=%b",
                           want.cross_x, want.cross_y, want.parallel, want.overflow,
                           rsp_data.cross_x, rsp_data.cross_y, rsp_data.parallel,
                           rsp_data.overflow);
            end
         end
      end
   end

   // Hold reset, drain all transfers, allow for latency, then decide.
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      wait (stimulus_done && pair_queue.size() == 0 && !start);
      wait (crossing_queue.size() == 0);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && crossing_queue.size() == 0)
         $display("line_line_intersection regression: pass");
      else
         $display("line_line_intersection regression: fail");
      $finish;
   end

   // Watchdog: far longer than the slowest correct run.
   initial begin
      #400000;
      $display("line_line_intersection regression: fail");
      $finish;
   end

endmodule
`default_nettype wire
